// File: src/pcg_pkg.sv
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared types and constants of the palette color grading pipeline.
// ----------------------------------------------------------------------------
package pcg_pkg;

   // pipeline depth: input register up to output register
   localparam int NUM_STAGES = 8;

   // load enables and valid bits of every stage
   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
      logic [NUM_STAGES-1:0] valid;
   } stage_ctl_type;

   typedef enum logic [1:0] {
      CSR_CONTRAST   = 2'd0,
      CSR_SATURATION = 2'd1,
      CSR_BRIGHTNESS = 2'd2
   } csr_index_type;

   localparam logic [3:0] CONTRAST_RESET   = 4'd12;
   localparam logic [3:0] SATURATION_RESET = 4'd9;
   localparam logic [3:0] BRIGHTNESS_RESET = 4'd7;

   localparam logic [3:0] LEVEL_NEUTRAL    = 4'd7;
   localparam logic [7:0] BRIGHT_BASE      = 8'd203;

   // floor(x/3) = (x*171) >> 9 for x below 384
   localparam logic [7:0]  RECIP_3         = 8'd171;
   localparam int          RECIP_3_SHIFT   = 9;
   // floor(x/196) = (x*10700) >> 21 for x below 43690
   localparam logic [13:0] RECIP_196       = 14'd10700;
   localparam int          RECIP_196_SHIFT = 21;
   // half of 196, for rounding to nearest
   localparam logic [13:0] HALF_196        = 14'd98;

   localparam logic [6:0] CONTRAST_PEAK    = 7'd78;
   localparam logic [6:0] QUOTIENT_PEAK    = 7'd66;

   // round(16*m*(63-m)/3969), symmetric about 31.5
   function automatic logic [2:0] contrast_gain(logic [5:0] m);
      logic [5:0] mm;
      logic [2:0] gain;
      mm = (m > 6'd31) ? (6'd63 - m) : m;
      case (mm) inside
         [6'd0:6'd2]:   gain = 3'd0;
         [6'd3:6'd6]:   gain = 3'd1;
         [6'd7:6'd12]:  gain = 3'd2;
         [6'd13:6'd20]: gain = 3'd3;
         default:       gain = 3'd4;
      endcase
      return gain;
   endfunction

endpackage

// File: src/pcg_flow.sv
// ----------------------------------------------------------------------------
// pcg_flow
// Valid bits and per-stage load enables of the grading pipeline.
// ----------------------------------------------------------------------------
module pcg_flow (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pcg_pkg::stage_ctl_type ctl
);

   logic [pcg_pkg::NUM_STAGES-1:0] valid_ff;
   logic [pcg_pkg::NUM_STAGES-1:0] valid_in;
   logic [pcg_pkg::NUM_STAGES:0]   ready;

   // a stage takes new data when empty or when its item moves on
   always_comb begin
      ready[pcg_pkg::NUM_STAGES] = out_ready;
      for (int i = pcg_pkg::NUM_STAGES - 1; i >= 0; i--) begin
         ready[i] = !valid_ff[i] || ready[i+1];
      end
   end

   always_comb begin
      valid_in[0] = ready[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < pcg_pkg::NUM_STAGES; i++) begin
         valid_in[i] = ready[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = ready[0];
   assign out_valid = valid_ff[pcg_pkg::NUM_STAGES-1];
   assign ctl.load  = ready[pcg_pkg::NUM_STAGES-1:0];
   assign ctl.valid = valid_ff;

endmodule

// File: src/palette_color_grading.sv
// ----------------------------------------------------------------------------
// palette_color_grading
// Grades one 6-bit RGB palette entry (contrast, saturation, brightness) and
// returns the 8-bit entry.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | direction
//  ---------+-----------------------------------------+----------
//  req      | req_valid/req_ready, req_{red,green,blue}_in  | in
//  rsp      | rsp_valid/rsp_ready, rsp_{red,green,blue}_out | out
//  csr      | csr_wr_en, csr_index, csr_wr_data       | in
//
//  One item per cycle while rsp is not stalled; the accepting edge loads the
//  req item into the first of the eight register stages of the datapath, and
//  rsp_valid rises once the item reaches the last.
//  Reset clears all stage valid bits and loads the levels 12, 9 and 7.
//  A stalled rsp holds the last stage; earlier stages keep moving into empty
//  slots, so req_ready falls only when every stage holds an item.
// ----------------------------------------------------------------------------
module palette_color_grading (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [5:0] req_red_in,
   input  logic [5:0] req_green_in,
   input  logic [5:0] req_blue_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_red_out,
   output logic [7:0] rsp_green_out,
   output logic [7:0] rsp_blue_out,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [3:0] csr_wr_data
);

   pcg_pkg::stage_ctl_type ctl;

   pcg_flow u_flow (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .ctl       (ctl)
   );

   // ------------------------------------------------------------------
   // level registers
   // ------------------------------------------------------------------
   logic [3:0] contrast_ff, contrast_in;
   logic [3:0] saturation_ff, saturation_in;
   logic [3:0] brightness_ff, brightness_in;

   always_comb begin
      contrast_in   = contrast_ff;
      saturation_in = saturation_ff;
      brightness_in = brightness_ff;
      if (csr_wr_en) begin
         case (csr_index)
            pcg_pkg::CSR_CONTRAST:   contrast_in   = csr_wr_data;
            pcg_pkg::CSR_SATURATION: saturation_in = csr_wr_data;
            pcg_pkg::CSR_BRIGHTNESS: brightness_in = csr_wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         contrast_ff   <= pcg_pkg::CONTRAST_RESET;
         saturation_ff <= pcg_pkg::SATURATION_RESET;
         brightness_ff <= pcg_pkg::BRIGHTNESS_RESET;
      end else begin
         contrast_ff   <= contrast_in;
         saturation_ff <= saturation_in;
         brightness_ff <= brightness_in;
      end
   end

   logic signed [4:0] contrast_trim;
   logic signed [4:0] saturation_trim;
   logic        [7:0] bright_factor;

   assign contrast_trim   = $signed({1'b0, contrast_ff}) - $signed({1'b0, pcg_pkg::LEVEL_NEUTRAL});
   assign saturation_trim = $signed({1'b0, saturation_ff})
                            - $signed({1'b0, pcg_pkg::LEVEL_NEUTRAL});
   assign bright_factor   = pcg_pkg::BRIGHT_BASE - {4'b0, brightness_ff};

   // ------------------------------------------------------------------
   // stage 0: capture entry, contrast gain from the peak component
   // ------------------------------------------------------------------
   logic [5:0] s0_chan_ff [3];
   logic [5:0] s0_chan_in [3];
   logic [2:0] s0_gain_ff, s0_gain_in;
   logic [5:0] s0_peak;

   always_comb begin
      s0_chan_in[0] = req_red_in;
      s0_chan_in[1] = req_green_in;
      s0_chan_in[2] = req_blue_in;
      s0_peak = (req_red_in > req_green_in) ? req_red_in : req_green_in;
      s0_peak = (s0_peak > req_blue_in) ? s0_peak : req_blue_in;
      s0_gain_in = pcg_pkg::contrast_gain(s0_peak);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[0]) begin
         s0_chan_ff <= s0_chan_in;
         s0_gain_ff <= s0_gain_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: component times gain
   // ------------------------------------------------------------------
   logic [5:0] s1_chan_ff [3];
   logic [8:0] s1_prod_ff [3];
   logic [8:0] s1_prod_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_prod_in[i] = 9'(s0_chan_ff[i]) * 9'(s0_gain_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[1]) begin
         s1_chan_ff <= s0_chan_ff;
         s1_prod_ff <= s1_prod_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: contrast, offset truncated toward zero
   // ------------------------------------------------------------------
   logic        [6:0]  s2_con_ff [3];
   logic        [6:0]  s2_con_in [3];
   logic signed [11:0] s2_scaled [3];
   logic        [11:0] s2_mag    [3];
   logic        [4:0]  s2_shift  [3];
   logic signed [7:0]  s2_offset [3];
   logic signed [7:0]  s2_sum    [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_scaled[i] = $signed({3'b0, s1_prod_ff[i]}) * contrast_trim;
         s2_mag[i]    = s2_scaled[i][11] ? 12'(-s2_scaled[i]) : 12'(s2_scaled[i]);
         s2_shift[i]  = 5'(s2_mag[i] >> 7);
         s2_offset[i] = s2_scaled[i][11] ? -$signed({3'b0, s2_shift[i]})
                                         : $signed({3'b0, s2_shift[i]});
         s2_sum[i]    = $signed({2'b0, s1_chan_ff[i]}) + s2_offset[i];
         s2_con_in[i] = s2_sum[i][6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[2]) begin
         s2_con_ff <= s2_con_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: integer mean of the three components
   // ------------------------------------------------------------------
   logic [6:0]  s3_con_ff [3];
   logic [6:0]  s3_avg_ff, s3_avg_in;
   logic [7:0]  s3_total;
   logic [15:0] s3_recip;

   always_comb begin
      s3_total  = 8'(s2_con_ff[0]) + 8'(s2_con_ff[1]) + 8'(s2_con_ff[2]);
      s3_recip  = 16'(s3_total) * 16'(pcg_pkg::RECIP_3);
      s3_avg_in = 7'(s3_recip >> pcg_pkg::RECIP_3_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (ctl.load[3]) begin
         s3_con_ff <= s2_con_ff;
         s3_avg_ff <= s3_avg_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 4: saturation around the mean, rounded, clamped
   // ------------------------------------------------------------------
   logic        [5:0]  s4_sat_ff [3];
   logic        [5:0]  s4_sat_in [3];
   logic signed [7:0]  s4_diff   [3];
   logic signed [10:0] s4_scaled [3];
   logic        [10:0] s4_mag    [3];
   logic        [6:0]  s4_rmag   [3];
   logic signed [9:0]  s4_round  [3];
   logic signed [9:0]  s4_sum    [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s4_diff[i]   = $signed({1'b0, s3_con_ff[i]}) - $signed({1'b0, s3_avg_ff});
         s4_scaled[i] = s4_diff[i] * saturation_trim;
         s4_mag[i]    = s4_scaled[i][10] ? 11'(-s4_scaled[i]) : 11'(s4_scaled[i]);
         s4_rmag[i]   = 7'((s4_mag[i] + 11'd4) >> 3);
         s4_round[i]  = s4_scaled[i][10] ? -$signed({3'b0, s4_rmag[i]})
                                         : $signed({3'b0, s4_rmag[i]});
         s4_sum[i]    = $signed({3'b0, s3_con_ff[i]}) + s4_round[i];
         if (s4_sum[i] < 10'sd0) begin
            s4_sat_in[i] = 6'd0;
         end else if (s4_sum[i] > 10'sd63) begin
            s4_sat_in[i] = 6'd63;
         end else begin
            s4_sat_in[i] = s4_sum[i][5:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[4]) begin
         s4_sat_ff <= s4_sat_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 5: distance from white times brightness factor, dark test
   // ------------------------------------------------------------------
   logic [13:0] s5_dist_ff [3];
   logic [13:0] s5_dist_in [3];
   logic        s5_dark_ff, s5_dark_in;
   logic [1:0]  s5_mlo_ff, s5_mlo_in;
   logic [5:0]  s5_peak;

   always_comb begin
      s5_peak = (s4_sat_ff[0] > s4_sat_ff[1]) ? s4_sat_ff[0] : s4_sat_ff[1];
      s5_peak = (s5_peak > s4_sat_ff[2]) ? s5_peak : s4_sat_ff[2];
      s5_dark_in = (s5_peak < 6'd3);
      s5_mlo_in  = s5_peak[1:0];
      for (int i = 0; i < 3; i++) begin
         s5_dist_in[i] = 14'(7'd64 - {1'b0, s4_sat_ff[i]}) * 14'(bright_factor);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[5]) begin
         s5_dist_ff <= s5_dist_in;
         s5_dark_ff <= s5_dark_in;
         s5_mlo_ff  <= s5_mlo_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 6: divide by 196 with rounding, by reciprocal
   // ------------------------------------------------------------------
   logic [6:0]  s6_quo_ff [3];
   logic [6:0]  s6_quo_in [3];
   logic [13:0] s6_biased [3];
   logic [27:0] s6_recip  [3];
   logic        s6_dark_ff;
   logic [1:0]  s6_mlo_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s6_biased[i] = s5_dist_ff[i] + pcg_pkg::HALF_196;
         s6_recip[i]  = 28'(s6_biased[i]) * 28'(pcg_pkg::RECIP_196);
         s6_quo_in[i] = 7'(s6_recip[i] >> pcg_pkg::RECIP_196_SHIFT);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[6]) begin
         s6_quo_ff  <= s6_quo_in;
         s6_dark_ff <= s5_dark_ff;
         s6_mlo_ff  <= s5_mlo_ff;
      end
   end

   // ------------------------------------------------------------------
   // stage 7: level, dark scaling, clamp, times four
   // ------------------------------------------------------------------
   // trunc(level*m/3) for a peak below 3; negatives clamp to zero later
   function automatic logic signed [7:0] dark_scale(logic signed [7:0] level,
                                                    logic [1:0] m_lo);
      logic signed [7:0] scaled;
      scaled = 8'sd0;
      case (m_lo)
         2'd1: begin
            scaled = (level >= 8'sd3) ? 8'sd1 : 8'sd0;
         end
         2'd2: begin
            if (level >= 8'sd5) begin
               scaled = 8'sd3;
            end else if (level >= 8'sd3) begin
               scaled = 8'sd2;
            end else if (level == 8'sd2) begin
               scaled = 8'sd1;
            end
         end
         default: scaled = 8'sd0;
      endcase
      return scaled;
   endfunction

   logic        [7:0] s7_out_ff [3];
   logic        [7:0] s7_out_in [3];
   logic signed [7:0] s7_level  [3];
   logic signed [7:0] s7_final  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s7_level[i] = 8'sd64 - $signed({1'b0, s6_quo_ff[i]});
         s7_final[i] = s6_dark_ff ? dark_scale(s7_level[i], s6_mlo_ff) : s7_level[i];
         if (s7_final[i] < 8'sd0) begin
            s7_out_in[i] = 8'd0;
         end else if (s7_final[i] > 8'sd63) begin
            s7_out_in[i] = {6'd63, 2'b00};
         end else begin
            s7_out_in[i] = {s7_final[i][5:0], 2'b00};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load[7]) begin
         s7_out_ff <= s7_out_in;
      end
   end

   assign rsp_red_out   = s7_out_ff[0];
   assign rsp_green_out = s7_out_ff[1];
   assign rsp_blue_out  = s7_out_ff[2];

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // the pipeline backs up only behind a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("req_ready low without a stalled result");

   // contrast result stays within its unclamped range
   assert property (@(posedge clock) disable iff (reset)
      ctl.valid[2] |-> (s2_con_ff[0] <= pcg_pkg::CONTRAST_PEAK)
                    && (s2_con_ff[1] <= pcg_pkg::CONTRAST_PEAK)
                    && (s2_con_ff[2] <= pcg_pkg::CONTRAST_PEAK))
      else $error("contrast stage out of range");

   // rounded brightness quotient never exceeds its bound
   assert property (@(posedge clock) disable iff (reset)
      ctl.valid[6] |-> (s6_quo_ff[0] <= pcg_pkg::QUOTIENT_PEAK)
                    && (s6_quo_ff[1] <= pcg_pkg::QUOTIENT_PEAK)
                    && (s6_quo_ff[2] <= pcg_pkg::QUOTIENT_PEAK))
      else $error("brightness quotient out of range");

endmodule
